/* sv/csv_order_record_parser_defines.svh */
// Assertion macros shared by the CSV order-record parser modules.
// Needs clk and rst_n in the scope of every use; define NO_ASSERTIONS to drop them.
`ifndef CSV_ORDER_RECORD_PARSER_DEFINES_SVH
`define CSV_ORDER_RECORD_PARSER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define COP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: property failed");
`define COP_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition seen");
`else
`define COP_ASSERT(lbl, prop)
`define COP_NEVER(lbl, cond)
`endif
`endif

/* sv/cop_pkg.sv */
// Shared types and constants of the CSV order-record parser.
// No dependencies; used by cop_parse_core, cop_rec_queue and the top level.
package cop_pkg;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_B     = 8'h42;

  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

  localparam int CFG_ADDR_W = 3;
  localparam logic REG_SKIP_HEADER = 1'b0;

  typedef struct packed {
    logic signed [31:0] quantity;
    logic signed [31:0] limit_price;
    logic               buy_side;
    logic [7:0]         message_kind;
    logic [63:0]        order_key;
    logic [63:0]        record_time;
  } rec_t;

  typedef struct packed {
    logic last;
    rec_t rec;
  } out_rec_t;

  typedef struct packed {
    logic a;
    logic b;
  } push_t;

  localparam int REC_W       = $bits(rec_t);
  localparam int OUT_TDATA_W = ((REC_W + 7) / 8) * 8;

endpackage

/* sv/cop_parse_core.sv */
// Byte parser of the CSV order-record parser: input word register, field state
// and the combinational step that yields up to two records per byte. Depends on cop_pkg.
`include "csv_order_record_parser_defines.svh"
module cop_parse_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              skip_header,
  input  logic              in_acc,
  input  logic [7:0]        in_byte,
  input  logic              in_eos,
  output cop_pkg::push_t    push,
  output cop_pkg::out_rec_t rec_a,
  output cop_pkg::out_rec_t rec_b
);
  import cop_pkg::*;

  typedef enum logic [2:0] {
    F_TIME  = 3'd0,
    F_KEY   = 3'd1,
    F_KIND  = 3'd2,
    F_SIDE  = 3'd3,
    F_PRICE = 3'd4,
    F_QTY   = 3'd5
  } field_t;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_BODY  = 2'd1,
    PH_DELIM = 2'd2,
    PH_LINE  = 2'd3
  } phase_t;

  logic        byte_vld_r;
  logic [7:0]  byte_r;
  logic        eos_r;

  logic        hdone_r,  hdone_nxt;
  field_t      fn_r,     fn_nxt;
  phase_t      ph_r,     ph_nxt;
  logic [63:0] val_r,    val_nxt;
  logic        mn_r,     mn_nxt;
  logic        open_r,   open_nxt;
  logic [63:0] time_r,   time_nxt;
  logic [63:0] key_r,    key_nxt;
  logic [7:0]  kind_r,   kind_nxt;
  logic        buy_r,    buy_nxt;
  logic [31:0] price_r,  price_nxt;

  logic        is_dlm, is_dig, is_nul, do_start;
  logic [3:0]  dig_val;
  logic [63:0] addend, acc;
  logic [31:0] flush_qty;

  function automatic out_rec_t mk_rec(input logic [63:0] t, input logic [63:0] k,
                                      input logic [7:0] kd, input logic by,
                                      input logic [31:0] pr, input logic [31:0] q);
    out_rec_t r;
    r.last             = 1'b0;
    r.rec.record_time  = t;
    r.rec.order_key    = k;
    r.rec.message_kind = kd;
    r.rec.buy_side     = by;
    r.rec.limit_price  = pr;
    r.rec.quantity     = q;
    return r;
  endfunction

  assign is_dlm  = (byte_r == CH_COMMA) || (byte_r == CH_LF) || (byte_r == CH_CR);
  assign is_dig  = (byte_r >= CH_ZERO) && (byte_r <= CH_NINE);
  assign is_nul  = (byte_r == CH_NUL);
  assign dig_val = 4'(byte_r - CH_ZERO);
  assign addend  = mn_r ? (64'd0 - {60'd0, dig_val}) : {60'd0, dig_val};
  assign acc     = (val_r << 3) + (val_r << 1) + addend;

  always_comb begin
    hdone_nxt = hdone_r;
    fn_nxt    = fn_r;
    ph_nxt    = ph_r;
    val_nxt   = val_r;
    mn_nxt    = mn_r;
    open_nxt  = open_r;
    time_nxt  = time_r;
    key_nxt   = key_r;
    kind_nxt  = kind_r;
    buy_nxt   = buy_r;
    price_nxt = price_r;
    push      = '0;
    rec_a     = '0;
    rec_b     = '0;
    do_start  = 1'b0;
    flush_qty = '0;

    if (byte_vld_r) begin
      if (skip_header && !hdone_r) begin
        if (byte_r == CH_LF) begin
          hdone_nxt = 1'b1;
          ph_nxt    = PH_LINE;
        end
      end else begin
        unique case (ph_r)
          PH_LINE:  do_start = !((byte_r == CH_LF) || (byte_r == CH_CR));
          PH_DELIM: do_start = !is_dlm;
          PH_START: do_start = 1'b1;
          PH_BODY: begin
            if (fn_r == F_KIND || fn_r == F_SIDE) begin
              if (is_dlm) begin
                fn_nxt = field_t'(fn_r + 3'd1);
                ph_nxt = PH_DELIM;
              end else if (is_nul) begin
                fn_nxt   = field_t'(fn_r + 3'd1);
                do_start = 1'b1;
              end
            end else if (is_dig) begin
              val_nxt = acc;
            end else begin
              unique case (fn_r)
                F_TIME: begin
                  time_nxt = val_r;
                  fn_nxt   = F_KEY;
                end
                F_KEY: begin
                  key_nxt = val_r;
                  fn_nxt  = F_KIND;
                end
                F_PRICE: begin
                  price_nxt = val_r[31:0];
                  fn_nxt    = F_QTY;
                end
                default: begin
                  rec_a     = mk_rec(time_r, key_r, kind_r, buy_r, price_r, val_r[31:0]);
                  push.a    = 1'b1;
                  time_nxt  = '0;
                  key_nxt   = '0;
                  kind_nxt  = '0;
                  buy_nxt   = 1'b0;
                  price_nxt = '0;
                  open_nxt  = 1'b0;
                  fn_nxt    = F_TIME;
                end
              endcase
              val_nxt = '0;
              mn_nxt  = 1'b0;
              if (is_dlm) begin
                ph_nxt = PH_DELIM;
              end else begin
                ph_nxt   = PH_START;
                do_start = 1'b1;
              end
            end
          end
        endcase

        if (do_start) begin
          if (fn_nxt == F_KIND || fn_nxt == F_SIDE) begin
            if (fn_nxt == F_KIND) begin
              kind_nxt = byte_r;
            end else begin
              buy_nxt = (byte_r == CH_B);
            end
            if (is_dlm || is_nul) begin
              fn_nxt = field_t'(fn_nxt + 3'd1);
              ph_nxt = PH_DELIM;
            end else begin
              ph_nxt = PH_BODY;
            end
          end else begin
            if (fn_nxt == F_TIME) begin
              open_nxt = 1'b1;
            end
            val_nxt = '0;
            mn_nxt  = 1'b0;
            if (is_dig) begin
              val_nxt = {60'd0, dig_val};
              ph_nxt  = PH_BODY;
            end else if (byte_r == CH_MINUS && (fn_nxt == F_PRICE || fn_nxt == F_QTY)) begin
              mn_nxt = 1'b1;
              ph_nxt = PH_BODY;
            end else if (is_dlm) begin
              unique case (fn_nxt)
                F_TIME: begin
                  time_nxt = '0;
                  fn_nxt   = F_KEY;
                end
                F_KEY: begin
                  key_nxt = '0;
                  fn_nxt  = F_KIND;
                end
                F_PRICE: begin
                  price_nxt = '0;
                  fn_nxt    = F_QTY;
                end
                default: begin
                  rec_a     = mk_rec(time_nxt, key_nxt, kind_nxt, buy_nxt, price_nxt, 32'd0);
                  push.a    = 1'b1;
                  time_nxt  = '0;
                  key_nxt   = '0;
                  kind_nxt  = '0;
                  buy_nxt   = 1'b0;
                  price_nxt = '0;
                  open_nxt  = 1'b0;
                  fn_nxt    = F_TIME;
                end
              endcase
              ph_nxt = PH_DELIM;
            end else begin
              // zero every numeric field up to the kind field, closing the record on the way
              if (fn_nxt == F_PRICE) begin
                price_nxt = '0;
              end
              if (fn_nxt == F_PRICE || fn_nxt == F_QTY) begin
                rec_a     = mk_rec(time_nxt, key_nxt, kind_nxt, buy_nxt, price_nxt, 32'd0);
                push.a    = 1'b1;
                time_nxt  = '0;
                buy_nxt   = 1'b0;
                price_nxt = '0;
              end
              if (fn_nxt != F_KEY) begin
                time_nxt = '0;
              end
              open_nxt = 1'b1;
              key_nxt  = '0;
              kind_nxt = byte_r;
              if (is_nul) begin
                fn_nxt = F_SIDE;
                ph_nxt = PH_DELIM;
              end else begin
                fn_nxt = F_KIND;
                ph_nxt = PH_BODY;
              end
            end
          end
        end
      end

      if (eos_r) begin
        if (open_nxt) begin
          if (ph_nxt == PH_BODY && !(fn_nxt == F_KIND || fn_nxt == F_SIDE)) begin
            unique case (fn_nxt)
              F_TIME:  time_nxt  = val_nxt;
              F_KEY:   key_nxt   = val_nxt;
              F_PRICE: price_nxt = val_nxt[31:0];
              default: flush_qty = val_nxt[31:0];
            endcase
          end
          if (push.a) begin
            rec_b  = mk_rec(time_nxt, key_nxt, kind_nxt, buy_nxt, price_nxt, flush_qty);
            push.b = 1'b1;
          end else begin
            rec_a  = mk_rec(time_nxt, key_nxt, kind_nxt, buy_nxt, price_nxt, flush_qty);
            push.a = 1'b1;
          end
        end
        hdone_nxt = 1'b0;
        fn_nxt    = F_TIME;
        ph_nxt    = PH_START;
        val_nxt   = '0;
        mn_nxt    = 1'b0;
        open_nxt  = 1'b0;
        time_nxt  = '0;
        key_nxt   = '0;
        kind_nxt  = '0;
        buy_nxt   = 1'b0;
        price_nxt = '0;
      end
    end

    rec_a.last = !push.b;
    rec_b.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    byte_r <= in_byte;
    eos_r  <= in_eos;
    if (!rst_n) begin
      byte_vld_r <= 1'b0;
      hdone_r    <= 1'b0;
      fn_r       <= F_TIME;
      ph_r       <= PH_START;
      val_r      <= '0;
      mn_r       <= 1'b0;
      open_r     <= 1'b0;
      time_r     <= '0;
      key_r      <= '0;
      kind_r     <= '0;
      buy_r      <= 1'b0;
      price_r    <= '0;
    end else begin
      byte_vld_r <= in_acc;
      hdone_r    <= hdone_nxt;
      fn_r       <= fn_nxt;
      ph_r       <= ph_nxt;
      val_r      <= val_nxt;
      mn_r       <= mn_nxt;
      open_r     <= open_nxt;
      time_r     <= time_nxt;
      key_r      <= key_nxt;
      kind_r     <= kind_nxt;
      buy_r      <= buy_nxt;
      price_r    <= price_nxt;
    end
  end

  `COP_ASSERT(a_two_only_at_end, push.b |-> (byte_vld_r && eos_r))
  `COP_ASSERT(a_end_clears, (byte_vld_r && eos_r) |=> (!open_r && fn_r == F_TIME && ph_r == PH_START))
  `COP_ASSERT(a_line_after_header, (ph_r == PH_LINE) |-> hdone_r)

endmodule

/* sv/cop_rec_queue.sv */
// Result queue of the CSV order-record parser: takes up to two records a cycle,
// hands out one a cycle when popped. Depends on cop_pkg.
`include "csv_order_record_parser_defines.svh"
module cop_rec_queue (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cop_pkg::push_t              push,
  input  cop_pkg::out_rec_t           rec_a,
  input  cop_pkg::out_rec_t           rec_b,
  input  logic                        pop,
  output cop_pkg::out_rec_t           head,
  output logic [cop_pkg::OUTQ_CNT_W-1:0] cnt
);
  import cop_pkg::*;

  out_rec_t               q_r [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [OUTQ_CNT_W-1:0]  cnt_r;
  logic [OUTQ_CNT_W-1:0]  push_cnt;
  logic [OUTQ_PTR_W-1:0]  wr_ptr_b;

  assign push_cnt = OUTQ_CNT_W'(push.a) + OUTQ_CNT_W'(push.b);
  assign wr_ptr_b = OUTQ_PTR_W'(wr_ptr_r + 1'b1);
  assign head     = q_r[rd_ptr_r];
  assign cnt      = cnt_r;

  always_ff @(posedge clk) begin
    if (push.a) begin
      q_r[wr_ptr_r] <= rec_a;
    end
    if (push.b) begin
      q_r[wr_ptr_b] <= rec_b;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= OUTQ_PTR_W'(wr_ptr_r + push_cnt);
      if (pop) begin
        rd_ptr_r <= OUTQ_PTR_W'(rd_ptr_r + 1'b1);
      end
      cnt_r <= OUTQ_CNT_W'(cnt_r + push_cnt - OUTQ_CNT_W'(pop));
    end
  end

  `COP_ASSERT(a_pair_order, push.b |-> push.a)
  `COP_NEVER(a_no_overflow, (cnt_r + push_cnt) > OUTQ_CNT_W'(OUTQ_DEPTH))
  `COP_ASSERT(a_no_underflow, pop |-> (cnt_r != '0))

endmodule

/* sv/csv_order_record_parser.sv */
// CSV order-record parser: takes one text byte per word and emits parsed order
// records (timestamp, key, kind, side, price, quantity). Throughput is one byte
// per cycle while in_tready is high; a byte is registered on acceptance and parsed
// in the next cycle, and its records are then written into the result queue and
// offered from it. A byte that ends a quantity, opens the next record and also ends
// the stream yields two records; these drain one per cycle while out_tready is high
// from a four-entry result queue, and the input stalls only while that queue cannot
// hold two more records. skip_header (address 0, reset 1) drops each stream's first line.
// Depends on cop_pkg, cop_parse_core and cop_rec_queue.
module csv_order_record_parser (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // [7:0] data_byte
  input  logic                             in_tlast,   // end_of_stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [63:0] record_time, [127:64] order_key, [135:128] message_kind,
  // [136] buy_side, [168:137] limit_price, [200:169] quantity, rest zero
  output logic [cop_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                             out_tlast,  // last_of_run
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cop_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import cop_pkg::*;

  logic                  skip_hdr_r;
  logic                  in_acc;
  push_t                 push;
  out_rec_t              rec_a, rec_b, head;
  logic [OUTQ_CNT_W-1:0] q_cnt;
  logic [OUTQ_CNT_W-1:0] push_cnt;
  logic                  reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[CFG_ADDR_W-1:2] == REG_SKIP_HEADER);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_hdr_r <= 1'b1;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      skip_hdr_r <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel) begin
      prdata[0] = skip_hdr_r;
    end
  end

  assign push_cnt  = OUTQ_CNT_W'(push.a) + OUTQ_CNT_W'(push.b);
  assign in_tready = (q_cnt + push_cnt) <= OUTQ_CNT_W'(OUTQ_DEPTH - 2);
  assign in_acc    = in_tvalid && in_tready;

  cop_parse_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .skip_header (skip_hdr_r),
    .in_acc      (in_acc),
    .in_byte     (in_tdata),
    .in_eos      (in_tlast),
    .push        (push),
    .rec_a       (rec_a),
    .rec_b       (rec_b)
  );

  cop_rec_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .rec_a (rec_a),
    .rec_b (rec_b),
    .pop   (out_tvalid && out_tready),
    .head  (head),
    .cnt   (q_cnt)
  );

  assign out_tvalid = (q_cnt != '0);
  assign out_tdata  = {{(OUT_TDATA_W - REC_W){1'b0}}, head.rec};
  assign out_tlast  = head.last;

endmodule

/* verif/tb_csv_order_record_parser.sv */
// Self-checking testbench for csv_order_record_parser: feeds CSV bytes, predicts order
// records in a local parser model or takes pinned ones from a script, and checks each
// output word field by field. Depends on cop_pkg and the csv_order_record_parser RTL.
module tb_csv_order_record_parser;
  import cop_pkg::*;

  localparam int SKIP_IDX       = int'(REG_SKIP_HEADER);
  localparam int SPARE_IDX      = SKIP_IDX + 1;
  localparam int SETTLE_CYCLES  = 4;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_BYTES    = 150;
  localparam int NUM_PHASES     = 5;

  typedef enum logic [1:0] {FLD_OPEN, FLD_BODY, FLD_GAP, FLD_EOL} fld_state_t;

  typedef struct {
    string text;
    logic  eos;
    logic  skip;
    logic  pinned;
    rec_t  want;
  } script_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [7:0]             in_tdata = '0;   // [7:0] data_byte
  logic                   in_tlast = 1'b0; // end_of_stream
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // [63:0] record_time, [127:64] order_key, [135:128] message_kind,
  // [136] buy_side, [168:137] limit_price, [200:169] quantity, rest zero
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;       // last_of_run
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]  paddr = '0;
  logic [31:0]            pwdata = '0;
  logic [31:0]            prdata;
  logic                   pready;

  // parser model state
  logic              skip_hdr;
  logic              hdr_seen;
  logic [2:0]        fld_idx;
  fld_state_t        fld_state;
  logic [63:0]       acc;
  logic              neg;
  logic              rec_live;
  logic [63:0]       p_time;
  logic [63:0]       p_key;
  logic [7:0]        p_kind;
  logic              p_buy;
  logic signed [31:0] p_price;

  out_rec_t    step_recs[$];
  out_rec_t    pending_records[$];
  logic [7:0]  line_buf[$];
  int          mismatches = 0;
  int          fed = 0;
  int          quiet = 0;
  logic        calm = 1'b0;
  logic        tx_gappy = 1'b1;
  logic        hold_req = 1'b0;

  csv_order_record_parser u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #5 clk = ~clk;

  function automatic logic is_sep(logic [7:0] b);
    return b == CH_COMMA || b == CH_LF || b == CH_CR;
  endfunction

  function automatic logic is_num(logic [7:0] b);
    return b >= CH_ZERO && b <= CH_NINE;
  endfunction

  function automatic logic char_field();
    return fld_idx == 3'd2 || fld_idx == 3'd3;
  endfunction

  function automatic rec_t mk_rec(logic [63:0] t, logic [63:0] k, logic [7:0] kind,
                                  logic buy, logic signed [31:0] price,
                                  logic signed [31:0] qty);
    rec_t r;
    r.record_time  = t;
    r.order_key    = k;
    r.message_kind = kind;
    r.buy_side     = buy;
    r.limit_price  = price;
    r.quantity     = qty;
    return r;
  endfunction

  function automatic void clear_stream();
    hdr_seen  = 1'b0;
    fld_idx   = 3'd0;
    fld_state = FLD_OPEN;
    acc       = '0;
    neg       = 1'b0;
    rec_live  = 1'b0;
    p_time    = '0;
    p_key     = '0;
    p_kind    = '0;
    p_buy     = 1'b0;
    p_price   = '0;
  endfunction

  function automatic void emit_rec(logic [31:0] qty);
    out_rec_t r;
    r.last = 1'b0;
    r.rec  = mk_rec(p_time, p_key, p_kind, p_buy, p_price, qty);
    step_recs = {step_recs, r};
    p_time   = '0;
    p_key    = '0;
    p_kind   = '0;
    p_buy    = 1'b0;
    p_price  = '0;
    rec_live = 1'b0;
  endfunction

  function automatic void close_number();
    logic [63:0] v;
    v   = neg ? 64'd0 - acc : acc;
    acc = '0;
    neg = 1'b0;
    if (fld_idx == 3'd0) begin
      p_time = v;
    end else if (fld_idx == 3'd1) begin
      p_key = v;
    end else if (fld_idx == 3'd4) begin
      p_price = v[31:0];
    end else begin
      fld_idx = 3'd0;
      emit_rec(v[31:0]);
      return;
    end
    fld_idx = fld_idx + 3'd1;
  endfunction

  function automatic void feed_byte(logic [7:0] b);
    logic again;
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      case (fld_state)
        FLD_EOL: begin
          if (b != CH_LF && b != CH_CR) begin
            fld_state = FLD_OPEN;
            again = 1'b1;
          end
        end
        FLD_GAP: begin
          if (!is_sep(b)) begin
            fld_state = FLD_OPEN;
            again = 1'b1;
          end
        end
        FLD_OPEN: begin
          if (fld_idx == 3'd0) rec_live = 1'b1;
          if (char_field()) begin
            if (fld_idx == 3'd2) p_kind = b;
            else p_buy = (b == CH_B);
            if (is_sep(b) || b == CH_NUL) begin
              fld_idx = fld_idx + 3'd1;
              fld_state = FLD_GAP;
            end else begin
              fld_state = FLD_BODY;
            end
          end else begin
            acc = '0;
            neg = 1'b0;
            if (is_num(b)) begin
              acc = 64'(b - CH_ZERO);
              fld_state = FLD_BODY;
            end else if (b == CH_MINUS && fld_idx >= 3'd4) begin
              neg = 1'b1;
              fld_state = FLD_BODY;
            end else begin
              close_number();
              if (is_sep(b)) begin
                fld_state = FLD_GAP;
              end else begin
                fld_state = FLD_OPEN;
                again = 1'b1;
              end
            end
          end
        end
        default: begin
          if (char_field()) begin
            if (is_sep(b)) begin
              fld_idx = fld_idx + 3'd1;
              fld_state = FLD_GAP;
            end else if (b == CH_NUL) begin
              fld_idx = fld_idx + 3'd1;
              fld_state = FLD_OPEN;
              again = 1'b1;
            end
          end else if (is_num(b)) begin
            acc = acc * 64'd10 + 64'(b - CH_ZERO);
          end else begin
            close_number();
            if (is_sep(b)) begin
              fld_state = FLD_GAP;
            end else begin
              fld_state = FLD_OPEN;
              again = 1'b1;
            end
          end
        end
      endcase
    end
  endfunction

  function automatic void parse_byte(logic [7:0] b, logic eos);
    logic [31:0] qty;
    logic [63:0] v;
    step_recs.delete();
    if (skip_hdr && !hdr_seen) begin
      if (b == CH_LF) begin
        hdr_seen = 1'b1;
        fld_state = FLD_EOL;
      end
    end else begin
      feed_byte(b);
    end
    if (eos) begin
      if (rec_live) begin
        qty = '0;
        if (fld_state == FLD_BODY && !char_field()) begin
          v = neg ? 64'd0 - acc : acc;
          if (fld_idx == 3'd0) p_time = v;
          else if (fld_idx == 3'd1) p_key = v;
          else if (fld_idx == 3'd4) p_price = v[31:0];
          else qty = v[31:0];
        end
        emit_rec(qty);
      end
      clear_stream();
    end
    if (step_recs.size() > 0) step_recs[step_recs.size() - 1].last = 1'b1;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : record_check
    rec_t     got;
    out_rec_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = rec_t'(out_tdata[REC_W-1:0]);
      if (pending_records.size() == 0) begin
        $display("%0t: unexpected record, expected none, actual %h", $time, out_tdata);
        mismatches++;
      end else begin
        want = pending_records.pop_front();
        check_field("record_time", want.rec.record_time, got.record_time);
        check_field("order_key", want.rec.order_key, got.order_key);
        check_field("message_kind", 64'(want.rec.message_kind), 64'(got.message_kind));
        check_field("buy_side", 64'(want.rec.buy_side), 64'(got.buy_side));
        check_field("limit_price", 64'(want.rec.limit_price), 64'(got.limit_price));
        check_field("quantity", 64'(want.rec.quantity), 64'(got.quantity));
        check_field("last_of_run", 64'(want.last), 64'(out_tlast));
        check_field("pad", '0, 64'(out_tdata[OUT_TDATA_W-1:REC_W]));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || psel) quiet = 0;
    else quiet++;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, quiet);
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : rx_side
    int rate;
    int span;
    rate = 0;
    span = 0;
    forever begin
      @(posedge clk);
      if (span == 0) begin
        span = 64;
        rate = $urandom_range(0, 2);
      end
      span--;
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_tready <= 1'b1;
      end else if (!calm && rate != 0 && $urandom_range(0, 2 * rate) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eos, input logic pinned,
                           input rec_t pin_rec);
    out_rec_t r;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eos;
    do @(posedge clk); while (!in_tready);
    fed++;
    parse_byte(b, eos);
    if (pinned) begin
      r.last = 1'b1;
      r.rec  = pin_rec;
      pending_records = {pending_records, r};
    end else begin
      foreach (step_recs[i]) pending_records = {pending_records, step_recs[i]};
    end
    if (!calm && tx_gappy && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input int idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(idx * 4);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == SKIP_IDX) skip_hdr = value[0];
    @(posedge clk);
  endtask

  task automatic cfg_read_check();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= CFG_ADDR_W'(SKIP_IDX * 4);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field("skip_header readback", 64'({31'd0, skip_hdr}), 64'(prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic void add_byte(logic [7:0] b);
    line_buf = {line_buf, b};
  endfunction

  function automatic void add_sep();
    int n;
    n = ($urandom_range(0, 7) == 0) ? 2 : 1;
    repeat (n) begin
      if ($urandom_range(0, 7) == 0) add_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
      else add_byte(CH_COMMA);
    end
  endfunction

  function automatic void add_number(logic signed_ok);
    int pick;
    int ndig;
    if ((signed_ok && $urandom_range(0, 2) == 0) || $urandom_range(0, 15) == 0)
      add_byte(CH_MINUS);
    pick = $urandom_range(0, 19);
    if (pick == 0) ndig = 0;
    else if (pick < 14) ndig = $urandom_range(1, 4);
    else if (pick < 18) ndig = $urandom_range(5, 10);
    else ndig = $urandom_range(11, 22);
    repeat (ndig) add_byte(CH_ZERO + 8'($urandom_range(0, 9)));
  endfunction

  function automatic void add_char(logic side);
    logic [7:0] c;
    if ($urandom_range(0, 7) == 0) c = 8'($urandom_range(0, 255));
    else if (side) c = $urandom_range(0, 1) ? CH_B : "S";
    else c = "A" + 8'($urandom_range(0, 25));
    add_byte(c);
    repeat ($urandom_range(0, 2)) add_byte("a" + 8'($urandom_range(0, 25)));
  endfunction

  function automatic void build_stream();
    logic [7:0] c;
    int         cut;
    line_buf.delete();
    if (skip_hdr) begin
      repeat ($urandom_range(0, 6)) begin
        c = 8'($urandom_range(0, 255));
        add_byte(c == CH_LF ? CH_COMMA : c);
      end
      add_byte(CH_LF);
      repeat ($urandom_range(0, 2)) add_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
    end
    repeat ($urandom_range(1, 6)) begin
      add_number(1'b0);
      add_sep();
      add_number(1'b0);
      add_sep();
      add_char(1'b0);
      add_sep();
      add_char(1'b1);
      add_sep();
      add_number(1'b1);
      add_sep();
      add_number(1'b1);
      case ($urandom_range(0, 3))
        0: begin
          add_byte(CH_CR);
          add_byte(CH_LF);
        end
        1: add_byte(CH_COMMA);
        default: add_byte(CH_LF);
      endcase
    end
    if ($urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 3))
        line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 3) == 0) begin
      cut = $urandom_range(1, line_buf.size());
      while (line_buf.size() > cut) void'(line_buf.pop_back());
    end
  endfunction

  initial begin
    script_row_t plan[7];
    logic [7:0]  c;
    logic        is_end;
    int          len;
    int          start;
    logic        held;
    logic        paused;

    skip_hdr = 1'b1;
    clear_stream();

    // '~' stands for NUL and '^' for 8'hFF in the text column
    plan[0] = '{"h\n\r", 1'b0, 1'b1, 1'b0, '0};
    plan[1] = '{"1,2,LS,B,-5,7\n", 1'b0, 1'b1, 1'b1, mk_rec(1, 2, "L", 1'b1, -5, 7)};
    plan[2] = '{"12", 1'b1, 1'b1, 1'b1, mk_rec(12, 0, 0, 1'b0, 0, 0)};
    plan[3] = '{"x\n,9", 1'b1, 1'b1, 1'b1, mk_rec(0, 9, 0, 1'b0, 0, 0)};
    plan[4] = '{"^", 1'b1, 1'b0, 1'b1, mk_rec(0, 0, 8'hFF, 1'b0, 0, 0)};
    plan[5] = '{"1-2,Q~-,5x", 1'b1, 1'b0, 1'b0, '0};
    plan[6] = '{"3,4,~,S,-,-7\n", 1'b1, 1'b0, 1'b1, mk_rec(3, 4, CH_NUL, 1'b0, 0, -7)};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[k]) begin
      if (plan[k].skip !== skip_hdr) begin
        settle();
        cfg_write(SKIP_IDX, {31'd0, plan[k].skip});
      end
      len = plan[k].text.len();
      for (int j = 0; j < len; j++) begin
        c = plan[k].text[j];
        if (c == "~") c = CH_NUL;
        else if (c == "^") c = 8'hFF;
        is_end = (j == len - 1);
        send_byte(c, plan[k].eos && is_end, plan[k].pinned && is_end, plan[k].want);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      cfg_write(SKIP_IDX, {31'd0, ph % 2 == 0});
      if (ph == 2) cfg_write(SPARE_IDX, 32'hFFFF_FFFF);
      cfg_read_check();
      calm   = (ph == NUM_PHASES - 1);
      start  = fed;
      held   = 1'b0;
      paused = 1'b0;
      while (fed - start < PHASE_BYTES) begin
        // back up the result side while bytes keep coming
        if (ph == 1 && !held && fed - start >= 40) begin
          hold_req = 1'b1;
          held = 1'b1;
        end
        if (ph == 2 && !paused && fed - start >= 60) begin
          settle();
          paused = 1'b1;
        end
        tx_gappy = $urandom_range(0, 2) != 0;
        build_stream();
        foreach (line_buf[i])
          send_byte(line_buf[i], i == line_buf.size() - 1, 1'b0, '0);
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
